// ===== hdl/assert_macros.svh =====
// Assertion macros for the register reply parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hdl/mrrp_pkg.sv =====
package mrrp_pkg;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0] ExceptionBase = 8'h80;
  localparam logic [7:0] EmptyUnitReset = 8'd5;
  localparam logic [7:0] FnReadHolding = 8'h03;
  localparam logic [7:0] FnReadInput = 8'h04;
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    StOk = 3'd0,
    StCrcBad = 3'd1,
    StEmpty = 3'd2,
    StException = 3'd3,
    StUnsupported = 3'd4
  } status_e;

  // one classified result going from front to back
  typedef struct packed {
    logic kind;
    logic [6:0] word_index;
    logic [15:0] word_value;
    logic [2:0] status;
    logic [6:0] word_count;
    logic [7:0] func_code;
  } result_t;

  typedef struct packed {
    logic frame_start;
    logic [7:0] rx_byte;
  } byte_t;

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction
endpackage

// ===== hdl/mrrp_if.sv =====
interface mrrp_byte_if;
  logic valid;
  logic ready;
  mrrp_pkg::byte_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrrp_result_if;
  logic valid;
  logic ready;
  mrrp_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mrrp_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/modbus_rtu_register_reply_parser.sv =====
// Channel   Dir  Payload
// in_i      in   frame_start, rx_byte
// out_o     out  kind, word_index, word_value, status, word_count, func_code
// cfg_i     in   empty_check_unit (8 bit)
// One byte per cycle; the CRC update is an unrolled 8-bit step in the front.
// A result is registered in the queue, then in the output register, before it appears.
// The front stalls only when the two-entry queue is full.
// Reset clears frame state, CRC to 0xFFFF and the unit register to 5.
`include "assert_macros.svh"
module modbus_rtu_register_reply_parser #(
  parameter int QueueDepth = mrrp_pkg::QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  mrrp_byte_if.sink in_i,
  mrrp_result_if.source out_o,
  mrrp_cfg_if.sink cfg_i
);
  logic [7:0] unit_q;
  logic f_valid, q_full, q_valid, q_ready;
  mrrp_pkg::result_t f_data, q_data;

  // config register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) unit_q <= mrrp_pkg::EmptyUnitReset;
    else if (cfg_i.valid) unit_q <= cfg_i.data;
  end

  mrrp_front u_front (
    .clk_i, .rst_ni, .empty_unit_i(unit_q),
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready), .in_data_i(in_i.data),
    .res_valid_o(f_valid), .res_data_o(f_data), .res_full_i(q_full)
  );

  mrrp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_data_i(f_data), .full_o(q_full),
    .rd_valid_o(q_valid), .rd_data_o(q_data), .rd_ready_i(q_ready)
  );

  mrrp_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .q_ready_o(q_ready),
    .out_o(out_o)
  );

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, f_valid && q_full, "result lost on full queue")
  `ASSERT_NEVER(a_word_clean, clk_i, rst_ni, out_o.valid && !out_o.data.kind && (out_o.data.status != mrrp_pkg::StOk), "word beat carries status")
  `ASSERT_IMPL(a_stall_hold, clk_i, rst_ni, out_o.valid && !out_o.ready |=> out_o.valid, "output dropped under stall")
endmodule

// ===== hdl/mrrp_front.sv =====
// Frame tracker: consumes bytes, updates CRC, classifies results
module mrrp_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [7:0] empty_unit_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  mrrp_pkg::byte_t in_data_i,
  output logic res_valid_o,
  output mrrp_pkg::result_t res_data_o,
  input  logic res_full_i
);
  logic [8:0] pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0] unit_q, unit_d, func_q, func_d, cnt_q, cnt_d;
  logic [7:0] high_q, high_d, crcl_q, crcl_d;
  logic [6:0] words_q, words_d;
  logic done_q, done_d;
  logic fire;
  logic [15:0] crc_next;
  logic [7:0] b;
  logic [8:0] end_pos;

  assign in_ready_o = !res_full_i;
  assign fire = in_valid_i && in_ready_o;
  assign b = in_data_i.rx_byte;
  assign crc_next = mrrp_pkg::crc_update(in_data_i.frame_start ? mrrp_pkg::CrcInit : crc_q, b);
  assign end_pos = {1'b0, cnt_q} + 9'd3;

  // next state and result per beat
  always_comb begin
    pos_d = pos_q; crc_d = crc_q; unit_d = unit_q; func_d = func_q; cnt_d = cnt_q;
    high_d = high_q; crcl_d = crcl_q; words_d = words_q; done_d = done_q;
    res_valid_o = 1'b0;
    res_data_o = '0;
    if (fire) begin
      if (in_data_i.frame_start) begin
        unit_d = b; crc_d = crc_next; func_d = '0; cnt_d = '0; high_d = '0;
        crcl_d = '0; words_d = '0; pos_d = 9'd1; done_d = 1'b0;
      end else if (!done_q) begin
        if (pos_q == 9'd1) begin
          func_d = b; crc_d = crc_next; pos_d = 9'd2;
        end else if (pos_q == 9'd2) begin
          cnt_d = b; crc_d = crc_next; pos_d = 9'd3;
          res_data_o.kind = 1'b1;
          if (unit_q == empty_unit_i && b == 8'd0) begin
            res_valid_o = 1'b1; done_d = 1'b1;
            res_data_o.status = mrrp_pkg::StEmpty;
          end else if (func_q >= mrrp_pkg::ExceptionBase) begin
            res_valid_o = 1'b1; done_d = 1'b1;
            res_data_o.status = mrrp_pkg::StException;
            res_data_o.func_code = func_q;
          end else if (func_q != mrrp_pkg::FnReadHolding && func_q != mrrp_pkg::FnReadInput) begin
            res_valid_o = 1'b1; done_d = 1'b1;
            res_data_o.status = mrrp_pkg::StUnsupported;
            res_data_o.func_code = func_q;
          end
        end else if (pos_q < end_pos) begin
          crc_d = crc_next; pos_d = pos_q + 9'd1;
          if (pos_q[0]) begin
            high_d = b;
          end else begin
            res_valid_o = 1'b1;
            res_data_o.word_index = words_q;
            res_data_o.word_value = {high_q, b};
            words_d = words_q + 7'd1;
          end
        end else if (pos_q == end_pos) begin
          crcl_d = b; pos_d = pos_q + 9'd1;
        end else begin
          res_valid_o = 1'b1; done_d = 1'b1;
          res_data_o.kind = 1'b1;
          if (crcl_q == crc_q[7:0] && b == crc_q[15:8]) begin
            res_data_o.status = mrrp_pkg::StOk;
            res_data_o.word_count = cnt_q[7:1];
          end else begin
            res_data_o.status = mrrp_pkg::StCrcBad;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; crc_q <= mrrp_pkg::CrcInit; unit_q <= '0; func_q <= '0;
      cnt_q <= '0; high_q <= '0; crcl_q <= '0; words_q <= '0; done_q <= 1'b1;
    end else begin
      pos_q <= pos_d; crc_q <= crc_d; unit_q <= unit_d; func_q <= func_d;
      cnt_q <= cnt_d; high_q <= high_d; crcl_q <= crcl_d; words_q <= words_d;
      done_q <= done_d;
    end
  end
endmodule

// ===== hdl/mrrp_queue.sv =====
// Small result FIFO between front and back; full flag stalls the front
module mrrp_queue #(
  parameter int Depth = mrrp_pkg::QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  input  mrrp_pkg::result_t wr_data_i,
  output logic full_o,
  output logic rd_valid_o,
  output mrrp_pkg::result_t rd_data_o,
  input  logic rd_ready_i
);
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
  mrrp_pkg::result_t mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0] cnt_q;
  logic wr, rd;

  assign full_o = (cnt_q == (Aw+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && !full_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == Aw'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == Aw'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end
endmodule

// ===== hdl/mrrp_back.sv =====
// Output stage: registered result beat toward the consumer
module mrrp_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  mrrp_pkg::result_t q_data_i,
  output logic q_ready_o,
  mrrp_result_if.source out_o
);
  logic valid_q;
  mrrp_pkg::result_t data_q;

  assign q_ready_o = !valid_q || out_o.ready;
  assign out_o.valid = valid_q;
  assign out_o.data = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (q_ready_o) valid_q <= q_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (q_ready_o && q_valid_i) data_q <= q_data_i;
  end
endmodule

// ===== tb/sv/modbus_rtu_register_reply_parser_tb.sv =====
module modbus_rtu_register_reply_parser_tb;

  // byte sources for a stimulus row
  localparam int ByteLit    = 0;
  localparam int ByteCrcLo  = 1;
  localparam int ByteCrcHi  = 2;
  localparam int ByteCrcBad = 3;

  localparam int IdlePct    = 6;
  localparam int StallLimit = 3000;

  typedef struct {
    bit                fs;
    logic [7:0]        val;
    int                src;
    bit                typed;
    mrrp_pkg::result_t res;
  } row_t;

  logic clk_i;
  logic rst_ni;
  int   cyc;
  int   quiet_cycles;
  int   errors;
  int   items_sent;

  mrrp_byte_if   in_if ();
  mrrp_result_if out_if ();
  mrrp_cfg_if    cfg_if ();

  modbus_rtu_register_reply_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // parser shadow state
  logic [7:0]  unit_sel;
  logic [8:0]  pos_q;
  logic [15:0] crc_q;
  logic [7:0]  unit_q, fn_q, count_q, high_q, crc_lo_q;
  logic [6:0]  words_q;
  bit          done_q;

  mrrp_pkg::result_t reply_q[$];
  row_t              rows[$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic mrrp_pkg::result_t status_res(mrrp_pkg::status_e st, logic [6:0] wc,
                                                   logic [7:0] fc);
    mrrp_pkg::result_t r;
    r = '0;
    r.kind = 1'b1;
    r.status = st;
    r.word_count = wc;
    r.func_code = fc;
    return r;
  endfunction

  // advance the shadow parser by one accepted byte
  task automatic parse_byte(input bit fs, input logic [7:0] b,
                            output bit has, output mrrp_pkg::result_t r);
    has = 1'b0;
    r = '0;
    if (fs) begin
      unit_q = b; crc_q = crc16_step(16'hFFFF, b);
      fn_q = '0; count_q = '0; high_q = '0; crc_lo_q = '0; words_q = '0;
      pos_q = 9'd1; done_q = 1'b0;
    end else if (!done_q) begin
      if (pos_q == 9'd1) begin
        fn_q = b; crc_q = crc16_step(crc_q, b); pos_q = 9'd2;
      end else if (pos_q == 9'd2) begin
        count_q = b; crc_q = crc16_step(crc_q, b); pos_q = 9'd3;
        has = 1'b1;
        if (unit_q == unit_sel && b == 8'd0) r = status_res(mrrp_pkg::StEmpty, '0, '0);
        else if (fn_q >= 8'h80) r = status_res(mrrp_pkg::StException, '0, fn_q);
        else if (fn_q != mrrp_pkg::FnReadHolding && fn_q != mrrp_pkg::FnReadInput)
          r = status_res(mrrp_pkg::StUnsupported, '0, fn_q);
        else has = 1'b0;
        if (has) done_q = 1'b1;
      end else if (pos_q < {1'b0, count_q} + 9'd3) begin
        crc_q = crc16_step(crc_q, b);
        if (pos_q[0] == 1'b1) high_q = b;
        else begin
          has = 1'b1;
          r.word_index = words_q;
          r.word_value = {high_q, b};
          words_q++;
        end
        pos_q++;
      end else if (pos_q == {1'b0, count_q} + 9'd3) begin
        crc_lo_q = b; pos_q++;
      end else begin
        has = 1'b1;
        done_q = 1'b1;
        if (crc_lo_q == crc_q[7:0] && b == crc_q[15:8])
          r = status_res(mrrp_pkg::StOk, count_q[7:1], '0);
        else
          r = status_res(mrrp_pkg::StCrcBad, '0, '0);
      end
    end
  endtask

  function automatic bit idle_now();
    if (cyc >= 2000 && cyc < 3500) return 1'b0;
    return $urandom_range(99) < IdlePct;
  endfunction

  // offer one byte and wait for its beat
  task automatic send_byte(input row_t rw);
    logic [7:0] b;
    bit has;
    mrrp_pkg::result_t r;
    while (idle_now()) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    case (rw.src)
      ByteCrcLo:  b = crc_q[7:0];
      ByteCrcHi:  b = crc_q[15:8];
      ByteCrcBad: b = crc_q[15:8] ^ (8'h01 << $urandom_range(7));
      default:    b = rw.val;
    endcase
    in_if.valid <= 1'b1;
    in_if.data  <= '{frame_start: rw.fs, rx_byte: b};
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    parse_byte(rw.fs, b, has, r);
    if (has) reply_q.push_back(r);
    if (rw.typed) begin
      if (!has || r !== rw.res) begin
        errors++;
        if (errors <= 10)
          $display("directed row mismatch: byte %h predicted %p listed %p", b, r, rw.res);
      end
    end
  endtask

  task automatic add_row(bit fs, logic [7:0] v, int src = ByteLit, bit typed = 1'b0,
                         mrrp_pkg::result_t res = '0);
    rows.push_back('{fs: fs, val: v, src: src, typed: typed, res: res});
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_unit(logic [7:0] v);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    unit_sel = v;
  endtask

  // one random reply, mostly well formed
  task automatic send_frame();
    logic [7:0] unit, fn, cnt;
    int kind, cut;
    kind = $urandom_range(99);
    unit = ($urandom_range(3) == 0) ? unit_sel : 8'($urandom);
    fn   = ($urandom_range(1) == 0) ? mrrp_pkg::FnReadHolding : mrrp_pkg::FnReadInput;
    if (kind < 8) fn = 8'($urandom);
    else if (kind < 14) fn = 8'h80 | 8'($urandom);
    cnt = ($urandom_range(29) == 0) ? 8'($urandom) : 8'($urandom_range(9));
    if ($urandom_range(7) == 0) cnt = 8'd0;
    cut = ($urandom_range(11) == 0) ? $urandom_range(int'(cnt) + 4) : -1;
    rows.delete();
    add_row(1'b1, unit);
    add_row(1'b0, fn);
    add_row(1'b0, cnt);
    for (int i = 0; i < cnt; i++) add_row(1'b0, 8'($urandom));
    add_row(1'b0, 8'h00, ByteCrcLo);
    add_row(1'b0, 8'h00, ($urandom_range(5) == 0) ? ByteCrcBad : ByteCrcHi);
    if ($urandom_range(9) == 0) add_row(1'b0, 8'($urandom));
    foreach (rows[i]) begin
      if (i == cut) break;
      send_byte(rows[i]);
    end
  endtask

  // receiver: random stalls plus one long hold-off
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (cyc >= 400 && cyc < 520) out_if.ready <= 1'b0;
      else if (cyc >= 2000 && cyc < 3500) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(99) >= IdlePct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_if.data);
      end else begin
        if (out_if.data !== reply_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: expected %p got %p", reply_q[0], out_if.data);
        end
        void'(reply_q.pop_front());
      end
    end
  end

  // watchdog on beats of any channel
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cyc = 0;
    quiet_cycles = 0;
    errors = 0;
    items_sent = 0;
    rst_ni <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    unit_sel = 8'd5;
    pos_q = '0; crc_q = 16'hFFFF; unit_q = '0; fn_q = '0; count_q = '0;
    high_q = '0; crc_lo_q = '0; words_q = '0; done_q = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: idle bytes, empty, exception, unsupported, normal, odd count with bad CRC, restart
    add_row(1'b0, 8'hFF);
    add_row(1'b0, 8'h00);
    add_row(1'b1, 8'h05); add_row(1'b0, 8'h03);
    add_row(1'b0, 8'h00, ByteLit, 1'b1, status_res(mrrp_pkg::StEmpty, '0, '0));
    add_row(1'b0, 8'h12);
    add_row(1'b1, 8'h01); add_row(1'b0, 8'h83);
    add_row(1'b0, 8'h02, ByteLit, 1'b1, status_res(mrrp_pkg::StException, '0, 8'h83));
    add_row(1'b1, 8'hFF); add_row(1'b0, 8'h06);
    add_row(1'b0, 8'h00, ByteLit, 1'b1, status_res(mrrp_pkg::StUnsupported, '0, 8'h06));
    add_row(1'b1, 8'h00); add_row(1'b0, 8'h03); add_row(1'b0, 8'h00);
    add_row(1'b0, 8'h00, ByteCrcLo);
    add_row(1'b0, 8'h00, ByteCrcHi, 1'b1, status_res(mrrp_pkg::StOk, '0, '0));
    add_row(1'b1, 8'h11); add_row(1'b0, 8'h04); add_row(1'b0, 8'h03);
    add_row(1'b0, 8'hFF); add_row(1'b0, 8'h00); add_row(1'b0, 8'hA5);
    add_row(1'b0, 8'h00, ByteCrcLo);
    add_row(1'b0, 8'h00, ByteCrcBad, 1'b1, status_res(mrrp_pkg::StCrcBad, '0, '0));
    add_row(1'b1, 8'h22); add_row(1'b0, 8'h03); add_row(1'b0, 8'h02);
    add_row(1'b1, 8'h22); add_row(1'b0, 8'h03); add_row(1'b0, 8'h02);
    add_row(1'b0, 8'h00); add_row(1'b0, 8'hFF);
    add_row(1'b0, 8'h00, ByteCrcLo);
    add_row(1'b0, 8'h00, ByteCrcHi, 1'b1, status_res(mrrp_pkg::StOk, 7'd1, '0));
    foreach (rows[i]) send_byte(rows[i]);

    // random phases over several unit settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_unit(8'h00);
        1: write_unit(8'hFF);
        2: write_unit(8'($urandom));
        default: write_unit(8'd5);
      endcase
      while (items_sent < (ph + 1) * 128) begin
        if ($urandom_range(9) == 0) begin
          rows.delete();
          add_row($urandom_range(1), 8'($urandom));
          send_byte(rows[0]);
        end else begin
          send_frame();
        end
      end
    end

    in_if.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
